@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the checker modules of this block.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This assertion is switched off while the reset input is high.
`define ASSERT_RST(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// This assertion is checked at every edge, reset cycles included.
`define ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

@@ rtl/core/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the RPN stack calculator
// This package holds the command and status codes, the controller states and
// the command and status bundles that connect the controller and the datapath.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 3;
  localparam int STAT_W          = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5
  } rsc_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIV0  = 2'd2,
    ST_OVER  = 2'd3
  } rsc_status_t;

  // These select which stack slot a memory access uses, relative to the count.
  typedef enum logic [1:0] {
    ADR_FREE   = 2'd0,
    ADR_TOP    = 2'd1,
    ADR_SECOND = 2'd2
  } rsc_addr_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_DEC2 = 2'd3
  } rsc_cnt_t;

  typedef enum logic [1:0] {
    RES_HOLD = 2'd0,
    RES_RD   = 2'd1,
    RES_ALU  = 2'd2,
    RES_QUO  = 2'd3
  } rsc_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_RD_S,
    S_LAT_S,
    S_EXEC,
    S_DIV,
    S_WB,
    S_FINISH
  } rsc_state_t;

  // These are the commands that the controller sends to the datapath.
  typedef struct packed {
    logic        capture;
    logic        rd_en;
    rsc_addr_t   rd_sel;
    logic        wr_en;
    rsc_addr_t   wr_sel;
    logic        wr_res;
    rsc_cnt_t    cnt_op;
    logic        lat_t;
    logic        lat_s;
    rsc_res_t    res_src;
    logic        st_load;
    rsc_status_t st_code;
    logic        div_start;
    logic        out_load;
  } rsc_cmd_t;

  // This is the status that the datapath returns to the controller.
  typedef struct packed {
    rsc_op_t op;
    logic    count_zero;
    logic    count_full;
    logic    count_lt2;
    logic    t_zero;
    logic    div_done;
    logic    out_busy;
  } rsc_stat_t;

endpackage

@@ rtl/core/rsc_div.sv @@
// ----------------------------------------------------------------------------
// rsc_div: iterative signed divider
// This unit is a restoring divider on magnitudes that retires one quotient bit
// per cycle and truncates the quotient toward zero.
// ----------------------------------------------------------------------------
module rsc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rsc_pkg::DATA_W-1:0] num,
  input  logic [rsc_pkg::DATA_W-1:0] den,
  output logic                      done,
  output logic [rsc_pkg::DATA_W-1:0] quo
);

  localparam int DW = rsc_pkg::DATA_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_mag;
  logic          neg;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem, q[DW-1]};
  assign fits    = shifted >= {1'b0, den_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q       <= num[DW-1] ? (DW'(0) - num) : num;
      den_mag <= den[DW-1] ? (DW'(0) - den) : den;
      neg     <= num[DW-1] ^ den[DW-1];
      rem     <= '0;
    end else if (busy) begin
      // The remainder stays below the divisor, so it always fits in DW bits.
      if (fits) begin
        rem <= DW'(shifted - {1'b0, den_mag});
      end else begin
        rem <= shifted[DW-1:0];
      end
      q <= {q[DW-2:0], fits};
    end
  end

  assign quo = neg ? (DW'(0) - q) : q;

endmodule

@@ rtl/core/rsc_dpath.sv @@
// ----------------------------------------------------------------------------
// rsc_dpath: datapath of the RPN stack calculator
// This module holds the stack memory, the entry count, the operand registers,
// the adder and multiplier, the divider and the output register.
// ----------------------------------------------------------------------------
module rsc_dpath #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rsc_pkg::OP_W-1:0]   in_cmd,
  input  logic [rsc_pkg::DATA_W-1:0] in_value,
  input  rsc_pkg::rsc_cmd_t          ctl,
  output rsc_pkg::rsc_stat_t         stat,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [rsc_pkg::STAT_W-1:0] out_status,
  output logic [rsc_pkg::DATA_W-1:0] out_value,
  output logic                       out_empty
);

  localparam int DW = rsc_pkg::DATA_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [DW-1:0]           mem [STACK_DEPTH];
  logic [DW-1:0]           rd_data;
  logic [CW-1:0]           count;
  logic [rsc_pkg::OP_W-1:0] op;
  logic [DW-1:0]           value_q;
  logic [DW-1:0]           t_reg;
  logic [DW-1:0]           s_reg;
  logic [DW-1:0]           res;
  rsc_pkg::rsc_status_t    status_q;
  logic [DW-1:0]           alu;
  logic [DW-1:0]           quo;
  logic                    div_done;
  logic [CW-1:0]           rd_slot;
  logic [CW-1:0]           wr_slot;

  function automatic logic [CW-1:0] slot(rsc_pkg::rsc_addr_t sel, logic [CW-1:0] cnt);
    logic [CW-1:0] s;
    case (sel)
      rsc_pkg::ADR_TOP:    s = cnt - CW'(1);
      rsc_pkg::ADR_SECOND: s = cnt - CW'(2);
      default:             s = cnt;
    endcase
    return s;
  endfunction

  assign rd_slot = slot(ctl.rd_sel, count);
  assign wr_slot = slot(ctl.wr_sel, count);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_slot[AW-1:0]] <= ctl.wr_res ? res : value_q;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_slot[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.cnt_op)
        rsc_pkg::CNT_INC:  count <= count + CW'(1);
        rsc_pkg::CNT_DEC:  count <= count - CW'(1);
        rsc_pkg::CNT_DEC2: count <= count - CW'(2);
        default:           count <= count;
      endcase
    end
  end

  always_comb begin
    case (rsc_pkg::rsc_op_t'(op))
      rsc_pkg::OP_SUB: alu = s_reg - t_reg;
      rsc_pkg::OP_MUL: alu = s_reg * t_reg;
      default:         alu = s_reg + t_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op       <= in_cmd;
      value_q  <= in_value;
      res      <= '0;
      status_q <= rsc_pkg::ST_OK;
    end else begin
      case (ctl.res_src)
        rsc_pkg::RES_RD:  res <= rd_data;
        rsc_pkg::RES_ALU: res <= alu;
        rsc_pkg::RES_QUO: res <= quo;
        default:          res <= res;
      endcase
      if (ctl.st_load) begin
        status_q <= ctl.st_code;
      end
    end
    if (ctl.lat_t) begin
      t_reg <= rd_data;
    end
    if (ctl.lat_s) begin
      s_reg <= rd_data;
    end
  end

  rsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (s_reg),
    .den   (t_reg),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status <= status_q;
      out_value  <= res;
      out_empty  <= count == '0;
    end
  end

  assign stat.op         = rsc_pkg::rsc_op_t'(op);
  assign stat.count_zero = count == '0;
  assign stat.count_full = count >= CW'(STACK_DEPTH);
  assign stat.count_lt2  = count < CW'(2);
  assign stat.t_zero     = t_reg == '0;
  assign stat.div_done   = div_done;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

@@ rtl/core/rsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsc_ctrl: sequencer of the RPN stack calculator
// This state machine walks each request through decode, stack reads, the
// operation and the write-back, and it hands the result to the output register.
// ----------------------------------------------------------------------------
module rsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsc_pkg::rsc_stat_t stat,
  output rsc_pkg::rsc_cmd_t  ctl
);

  rsc_pkg::rsc_state_t state;
  rsc_pkg::rsc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      rsc_pkg::S_IDLE: begin
        // No request is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          ctl.capture = 1'b1;
          state_next  = rsc_pkg::S_DECODE;
        end
      end
      rsc_pkg::S_DECODE: begin
        state_next = rsc_pkg::S_FINISH;
        case (stat.op)
          rsc_pkg::OP_PUSH: begin
            if (stat.count_full) begin
              ctl.st_load = 1'b1;
              ctl.st_code = rsc_pkg::ST_OVER;
            end else begin
              ctl.wr_en  = 1'b1;
              ctl.wr_sel = rsc_pkg::ADR_FREE;
              ctl.cnt_op = rsc_pkg::CNT_INC;
            end
          end
          rsc_pkg::OP_POP: begin
            if (stat.count_zero) begin
              ctl.st_load = 1'b1;
              ctl.st_code = rsc_pkg::ST_UNDER;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = rsc_pkg::ADR_TOP;
              state_next = rsc_pkg::S_POP;
            end
          end
          rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV: begin
            if (stat.count_lt2) begin
              ctl.st_load = 1'b1;
              ctl.st_code = rsc_pkg::ST_UNDER;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = rsc_pkg::ADR_TOP;
              state_next = rsc_pkg::S_RD_S;
            end
          end
          default: begin
            state_next = rsc_pkg::S_FINISH;
          end
        endcase
      end
      rsc_pkg::S_POP: begin
        ctl.res_src = rsc_pkg::RES_RD;
        ctl.cnt_op  = rsc_pkg::CNT_DEC;
        state_next  = rsc_pkg::S_FINISH;
      end
      rsc_pkg::S_RD_S: begin
        ctl.lat_t  = 1'b1;
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = rsc_pkg::ADR_SECOND;
        state_next = rsc_pkg::S_LAT_S;
      end
      rsc_pkg::S_LAT_S: begin
        ctl.lat_s  = 1'b1;
        state_next = rsc_pkg::S_EXEC;
      end
      rsc_pkg::S_EXEC: begin
        if (stat.op == rsc_pkg::OP_DIV) begin
          if (stat.t_zero) begin
            // Both operands are dropped and nothing is pushed.
            ctl.st_load = 1'b1;
            ctl.st_code = rsc_pkg::ST_DIV0;
            ctl.cnt_op  = rsc_pkg::CNT_DEC2;
            state_next  = rsc_pkg::S_FINISH;
          end else begin
            ctl.div_start = 1'b1;
            state_next    = rsc_pkg::S_DIV;
          end
        end else begin
          ctl.res_src = rsc_pkg::RES_ALU;
          state_next  = rsc_pkg::S_WB;
        end
      end
      rsc_pkg::S_DIV: begin
        if (stat.div_done) begin
          ctl.res_src = rsc_pkg::RES_QUO;
          state_next  = rsc_pkg::S_WB;
        end
      end
      rsc_pkg::S_WB: begin
        // The result replaces the second entry, and the stack shrinks by one.
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = rsc_pkg::ADR_SECOND;
        ctl.wr_res = 1'b1;
        ctl.cnt_op = rsc_pkg::CNT_DEC;
        state_next = rsc_pkg::S_FINISH;
      end
      rsc_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = rsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rsc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/rpn_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse-Polish integer stack calculator
// Requests arrive on the s_ channel with a command in s_tuser and an operand
// in s_tdata. Each request yields one response on the m_ channel.
// m_tvalid rises when the response is loaded at the final step. Push, unused
// commands and underflow go from decode to the final step; pop reads the top
// entry; add, subtract, multiply and divide read both operands and execute,
// a divide in the divider, which retires one quotient bit per cycle, and all
// but a divide by zero write back. The next request can be taken in the cycle
// after the response is loaded. The block takes one request at a time; s_tready
// is high only while the sequencer is idle and reset is released. The stack
// sits in a single-port memory of STACK_DEPTH words with a registered read.
// Reset clears the entry count and the output valid flag; the memory itself is
// not cleared because only written entries are ever read.
// A finished response waits in the output register while m_tready is low.
// Meanwhile the next request is still accepted and processed, and it waits
// only at its last step until the output register frees up.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_value
  output logic [2:0]  m_tuser    // [1:0] status, [2] empty_res
);

  rsc_pkg::rsc_cmd_t  ctl;
  rsc_pkg::rsc_stat_t stat;
  logic [rsc_pkg::STAT_W-1:0] out_status;
  logic                       out_empty;

  // The sequencer decides each step; the datapath holds all stack state.
  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  rsc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_tuser),
    .in_value   (s_tdata),
    .ctl        (ctl),
    .stat       (stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_value  (m_tdata),
    .out_empty  (out_empty)
  );

  // The response flags travel together in the sideband field.
  assign m_tuser = {out_empty, out_status};

endmodule

@@ rtl/core/rsc_checker.sv @@
// ----------------------------------------------------------------------------
// rsc_checker: port-level checks for the RPN stack calculator
// This checker watches the top-level stream ports and is bound to every
// instance of the calculator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // A stalled response stays offered.
  `ASSERT_RST(a_resp_held, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "response dropped while stalled")

  // A stalled response keeps its contents.
  `ASSERT_RST(a_resp_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "response changed while stalled")

  // Reset leaves no response pending.
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "response pending after reset")

  // Every error response carries a zero value.
  `ASSERT_RST(a_err_zero, clk, rst, m_tvalid && (m_tuser[1:0] != rsc_pkg::ST_OK) |-> m_tdata == 32'd0, "error response with nonzero value")

  // The block works on one request at a time, so it is busy right after taking one.
  `ASSERT_RST(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "request accepted back to back")

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RPN stack calculator
// A directed table covers underflow, overflow, divide by zero, wrap-around and
// the unused commands. Randomized requests then run in three idling phases.
// Responses are checked field by field against a stack model or a fixed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = rsc_pkg::STACK_DEPTH_DEF;
  localparam int          ITEMS_PHASE  = 600;
  localparam int          WATCHDOG_MAX = 5000;
  localparam int          TAIL_CYCLES  = 60;
  localparam int          ERR_PRINT    = 40;
  // Command codes 6 and 7 are not decoded by the block and must act as no-ops.
  localparam logic [2:0]  CMD_RSVD6    = 3'd6;
  localparam logic [2:0]  CMD_RSVD7    = 3'd7;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_NEG1     = 32'hFFFF_FFFF;

  // One response as the stack model predicts it.
  typedef struct packed {
    rsc_pkg::rsc_status_t status;
    logic [31:0]          value;
    logic                 empty;
  } resp_t;

  // One row of the directed table. Rows with fixed set carry an expected
  // response typed in by hand; the rest rely on the stack model.
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    int          rep;
    logic        fixed;
    resp_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  // Stack model state, updated once per accepted request.
  logic [31:0] model_stack [DEPTH];
  int          model_depth = 0;
  int          deepest     = 0;

  resp_t       resp_q[$];      // responses still owed by the block, oldest first
  dir_row_t    dir_tab[$];

  // The driver publishes a hand-typed expectation alongside the request.
  logic        fixed_on;
  resp_t       fixed_resp;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_req;
  int          hold_left   = 0;
  logic        fill_mode   = 1'b1;

  int          err_count   = 0;
  int          req_count   = 0;
  int          resp_count  = 0;
  int          stat_seen [4];
  int          quiet_cycles = 0;

  rpn_stack_calculator #(
    .STACK_DEPTH (DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] value
    .s_tuser  (s_tuser),   // [2:0] cmd
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] result_value
    .m_tuser  (m_tuser)    // [1:0] status, [2] empty_res
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed division with truncation toward zero, built on unsigned magnitudes.
  // The most negative value over minus one wraps back to itself.
  function automatic logic [31:0] trunc_quotient(input logic [31:0] num,
                                                 input logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    q     = mag_n / mag_d;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  // Applies one command to the stack model and returns the response it owes.
  function automatic resp_t rpn_eval(input logic [2:0] cmd, input logic [31:0] val);
    resp_t       r;
    logic [31:0] top_v;
    logic [31:0] sec_v;
    logic        push_back_res;
    r.status = rsc_pkg::ST_OK;
    r.value  = '0;
    case (cmd)
      rsc_pkg::OP_PUSH: begin
        if (model_depth >= DEPTH) begin
          r.status = rsc_pkg::ST_OVER;
        end else begin
          model_stack[model_depth] = val;
          model_depth++;
        end
      end
      rsc_pkg::OP_POP: begin
        if (model_depth == 0) begin
          r.status = rsc_pkg::ST_UNDER;
        end else begin
          model_depth--;
          r.value = model_stack[model_depth];
        end
      end
      rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV: begin
        if (model_depth < 2) begin
          r.status = rsc_pkg::ST_UNDER;
        end else begin
          top_v         = model_stack[model_depth-1];
          sec_v         = model_stack[model_depth-2];
          model_depth  -= 2;
          push_back_res = 1'b1;
          case (cmd)
            rsc_pkg::OP_ADD: r.value = sec_v + top_v;
            rsc_pkg::OP_SUB: r.value = sec_v - top_v;
            rsc_pkg::OP_MUL: r.value = sec_v * top_v;
            default: begin
              // A zero divisor drops both operands and pushes nothing.
              if (top_v == '0) begin
                r.status      = rsc_pkg::ST_DIV0;
                push_back_res = 1'b0;
              end else begin
                r.value = trunc_quotient(sec_v, top_v);
              end
            end
          endcase
          if (push_back_res) begin
            model_stack[model_depth] = r.value;
            model_depth++;
          end
        end
      end
      default: ;
    endcase
    r.empty = (model_depth == 0);
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] cmd, input logic [31:0] value,
                                      input int rep, input logic fixed,
                                      input rsc_pkg::rsc_status_t st,
                                      input logic [31:0] res, input logic empty);
    dir_row_t row;
    row.cmd         = cmd;
    row.value       = value;
    row.rep         = rep;
    row.fixed       = fixed;
    row.want.status = st;
    row.want.value  = res;
    row.want.empty  = empty;
    return row;
  endfunction

  // Operands lean toward the corners of the signed range and small numbers,
  // so that wrap-around, zero divisors and divide by minus one show up often.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_NEG1;
      3:       return 32'd0;
      4:       return 32'd1;
      5, 6, 7, 8, 9, 10, 11, 12:
               return 32'($urandom_range(40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= ERR_PRINT) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Offers one request and returns at the falling edge after it was taken.
  // The valid line is left high so that a following request can go out
  // back to back; whoever pauses afterwards lowers it.
  task automatic send_request(input logic [2:0] cmd, input logic [31:0] val,
                              input logic fixed, input resp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tuser    = cmd;
    s_tdata    = val;
    fixed_on   = fixed;
    fixed_resp = want;
    s_tvalid   = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Random requests alternate between a filling and a draining mood so the
  // stack swings between empty and full. A small share is pure noise.
  task automatic send_random_request();
    logic [2:0] cmd;
    int         push_pct;
    if ($urandom_range(19) == 0) fill_mode = !fill_mode;
    if ($urandom_range(99) < 8) begin
      cmd = 3'($urandom_range(7));
    end else begin
      push_pct = fill_mode ? 75 : 25;
      if (!fill_mode && model_depth < 2) push_pct = 70;
      if ($urandom_range(99) < push_pct) begin
        cmd = rsc_pkg::OP_PUSH;
      end else begin
        case ($urandom_range(4))
          0:       cmd = rsc_pkg::OP_POP;
          1:       cmd = rsc_pkg::OP_ADD;
          2:       cmd = rsc_pkg::OP_SUB;
          3:       cmd = rsc_pkg::OP_MUL;
          default: cmd = rsc_pkg::OP_DIV;
        endcase
      end
    end
    send_request(cmd, rand_operand(), 1'b0, fixed_resp);
  endtask

  // Waits with no request offered until every owed response has arrived,
  // then switches the idling mix and optionally arms a long output stall.
  task automatic begin_phase(input int sp, input int rp, input int hold);
    s_tvalid = 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
    @(posedge clk);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    hold_req      = hold;
    @(negedge clk);
  endtask

  // Response side. A requested hold loads hold_left and keeps tready low until it
  // runs out, while the sender keeps offering, so the block backs up and stalls.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Scoreboard. Responses are compared first, then the request accepted on
  // the same edge is run through the model and queued.
  always @(posedge clk) begin
    resp_t want;
    resp_t owed;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        resp_count++;
        if (resp_q.size() == 0) begin
          report_mismatch($sformatf("response %h/%h with no request outstanding",
                                    m_tuser, m_tdata));
        end else begin
          owed = resp_q.pop_front();
          if (m_tuser[1:0] !== owed.status)
            report_mismatch($sformatf("status got %0d want %0d (%s)", m_tuser[1:0],
                                      owed.status, owed.status.name()));
          if (m_tdata !== owed.value)
            report_mismatch($sformatf("result got %h want %h", m_tdata, owed.value));
          if (m_tuser[2] !== owed.empty)
            report_mismatch($sformatf("empty flag got %b want %b", m_tuser[2],
                                      owed.empty));
        end
      end
      if (s_tvalid && s_tready) begin
        req_count++;
        want = rpn_eval(s_tuser, s_tdata);
        if (fixed_on) want = fixed_resp;
        stat_seen[want.status]++;
        if (model_depth > deepest) deepest = model_depth;
        resp_q.push_back(want);
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means
  // the block has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no handshake for %0d cycles, %0d responses owed",
               quiet_cycles, resp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    fixed_on      = 1'b0;
    fixed_resp    = '{rsc_pkg::ST_OK, 32'd0, 1'b0};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    foreach (stat_seen[i]) stat_seen[i] = 0;

    // Directed table. It starts from an empty stack, walks through the error
    // codes and the wrap-around cases, then fills the stack to force overflow.
    dir_tab.push_back(mk_row(rsc_pkg::OP_POP,  32'd0,    1, 1, rsc_pkg::ST_UNDER, 32'd0, 1'b1));
    dir_tab.push_back(mk_row(rsc_pkg::OP_ADD,  32'd0,    1, 1, rsc_pkg::ST_UNDER, 32'd0, 1'b1));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, VAL_MAX,  1, 1, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_SUB,  32'd0,    1, 1, rsc_pkg::ST_UNDER, 32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, 32'd1,    1, 1, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_ADD,  32'd0,    1, 1, rsc_pkg::ST_OK,  VAL_MIN, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, VAL_NEG1, 1, 1, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_DIV,  32'd0,    1, 1, rsc_pkg::ST_OK,  VAL_MIN, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, 32'd0,    1, 1, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_DIV,  32'd0,    1, 1, rsc_pkg::ST_DIV0,  32'd0, 1'b1));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, -32'd7,   1, 0, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, 32'd2,    1, 0, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_DIV,  VAL_NEG1, 1, 0, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(CMD_RSVD6,        VAL_NEG1, 1, 1, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(CMD_RSVD7,        VAL_MIN,  1, 1, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_POP,  32'd0,    1, 0, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, 32'h5A5A_5A5A, DEPTH, 0, rsc_pkg::ST_OK,
                             32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_PUSH, 32'hA5A5_A5A5, 1, 1, rsc_pkg::ST_OVER,
                             32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_MUL,  32'd0,    1, 0, rsc_pkg::ST_OK,    32'd0, 1'b0));
    dir_tab.push_back(mk_row(rsc_pkg::OP_SUB,  32'd0,    1, 0, rsc_pkg::ST_OK,    32'd0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests run with an occasionally idle sender and a reluctant receiver.
    begin_phase(12, 70, 0);
    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].rep)
        send_request(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].fixed, dir_tab[i].want);
    end

    // Phase one: mostly stalls on the response side, opened by a long stall.
    begin_phase(12, 70, 200);
    repeat (ITEMS_PHASE) send_random_request();

    // Phase two: the sender is the one leaving gaps.
    begin_phase(70, 12, 0);
    repeat (ITEMS_PHASE) send_random_request();

    // Phase three: full rate on both sides, after a long stall that lets
    // requests pile up behind a held response.
    begin_phase(0, 0, 300);
    repeat (ITEMS_PHASE) send_random_request();

    s_tvalid = 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (resp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", resp_q.size()));

    $display("Checked %0d responses to %0d requests: ok %0d, underflow %0d, %s %0d, %s %0d.",
             resp_count, req_count, stat_seen[rsc_pkg::ST_OK], stat_seen[rsc_pkg::ST_UNDER],
             "divide by zero", stat_seen[rsc_pkg::ST_DIV0], "overflow",
             stat_seen[rsc_pkg::ST_OVER]);
    $display("Stack reached %0d of %0d entries across three idling mixes and two long stalls.",
             deepest, DEPTH);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
